// File: rtl/assert_macros.svh
// Assertion macros for the RTL; included by iida_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, disabled during reset.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/iida_pkg.sv
// Package: sizes, action and status codes, state type and memory request word.
package iida_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int LEN_W  = 7;
    localparam int ACT_W  = 2;
    localparam int STAT_W = 2;
    localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    localparam logic [ACT_W-1:0] ACT_GET    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SHIFT = 3'b010,
        ST_RESP  = 3'b100
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

// File: rtl/iida_mem.sv
// Element store: one write port, one read port, registered read data.
module iida_mem (
    input  logic                        clk,
    input  iida_pkg::mem_req_t          req,
    output logic [iida_pkg::DATA_W-1:0] rd_data
);

    logic [iida_pkg::DATA_W-1:0] mem [iida_pkg::DEPTH];
    logic [iida_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/iida_ctrl.sv
// Sequencer: checks each command, runs the shift through the store, builds the result.
`include "assert_macros.svh"

module iida_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [iida_pkg::ACT_W-1:0]  action,
    input  logic [iida_pkg::POS_W-1:0]  position,
    input  logic [iida_pkg::DATA_W-1:0] value,
    input  logic [iida_pkg::DATA_W-1:0] rd_data,
    output iida_pkg::mem_req_t          mem_req,
    output logic                        busy,
    output logic                        done,
    output logic [iida_pkg::DATA_W-1:0] read_value,
    output logic [iida_pkg::LEN_W-1:0]  length,
    output logic                        empty_res,
    output logic [iida_pkg::STAT_W-1:0] status
);

    iida_pkg::state_t                state_reg, state_next;
    logic [iida_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [iida_pkg::ACT_W-1:0]      act_reg, act_next;
    logic [iida_pkg::ADDR_W-1:0]     pos_reg, pos_next;
    logic [iida_pkg::DATA_W-1:0]     val_reg, val_next;
    logic [iida_pkg::STAT_W-1:0]     stat_reg, stat_next;
    logic [iida_pkg::ADDR_W-1:0]     last_reg, last_next;
    logic [iida_pkg::ADDR_W-1:0]     remain_reg, remain_next;

    logic                            accept;
    logic [iida_pkg::CMP_W-1:0]      cnt_x;
    logic [iida_pkg::CMP_W-1:0]      pos_x;
    logic [iida_pkg::STAT_W-1:0]     chk_stat;
    logic                            chk_ok;
    logic                            is_ins;
    logic                            is_del;
    logic                            shift_ins;
    logic                            shift_del;
    logic [iida_pkg::ADDR_W-1:0]     pos_a;

    assign accept = start && (state_reg == iida_pkg::ST_IDLE);
    assign cnt_x  = iida_pkg::CMP_W'(count_reg);
    assign pos_x  = iida_pkg::CMP_W'(position);
    assign pos_a  = iida_pkg::ADDR_W'(position);
    assign is_ins = (action == iida_pkg::ACT_INSERT);
    assign is_del = (action == iida_pkg::ACT_DELETE);

    always_comb
    begin
        chk_stat = iida_pkg::STAT_OK;
        case (action)
            iida_pkg::ACT_GET, iida_pkg::ACT_DELETE:
            begin
                if (count_reg == '0)
                begin
                    chk_stat = iida_pkg::STAT_EMPTY;
                end
                else if (pos_x >= cnt_x)
                begin
                    chk_stat = iida_pkg::STAT_RANGE;
                end
            end
            iida_pkg::ACT_INSERT:
            begin
                if (count_reg == iida_pkg::CNT_W'(iida_pkg::DEPTH))
                begin
                    chk_stat = iida_pkg::STAT_FULL;
                end
                else if (pos_x > cnt_x)
                begin
                    chk_stat = iida_pkg::STAT_RANGE;
                end
            end
            default:
            begin
                chk_stat = iida_pkg::STAT_OK;
            end
        endcase
    end

    assign chk_ok    = (chk_stat == iida_pkg::STAT_OK);
    assign shift_ins = is_ins && chk_ok && (pos_x < cnt_x);
    assign shift_del = is_del && chk_ok && ((pos_x + iida_pkg::CMP_W'(1)) < cnt_x);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        act_next    = act_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        stat_next   = stat_reg;
        last_next   = last_reg;
        remain_next = remain_reg;
        mem_req     = '0;
        case (state_reg)
            iida_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    act_next  = action;
                    pos_next  = pos_a;
                    val_next  = value;
                    stat_next = chk_stat;
                    if (is_ins && chk_ok)
                    begin
                        count_next = count_reg + iida_pkg::CNT_W'(1);
                    end
                    else if (is_del && chk_ok)
                    begin
                        count_next = count_reg - iida_pkg::CNT_W'(1);
                    end
                    if (shift_ins)
                    begin
                        mem_req.re  = 1'b1;
                        mem_req.raddr = iida_pkg::ADDR_W'(cnt_x - iida_pkg::CMP_W'(1));
                        remain_next = iida_pkg::ADDR_W'(cnt_x - pos_x - iida_pkg::CMP_W'(1));
                        state_next  = iida_pkg::ST_SHIFT;
                    end
                    else if (shift_del)
                    begin
                        mem_req.re  = 1'b1;
                        mem_req.raddr = pos_a + iida_pkg::ADDR_W'(1);
                        remain_next = iida_pkg::ADDR_W'(cnt_x - pos_x - iida_pkg::CMP_W'(2));
                        state_next  = iida_pkg::ST_SHIFT;
                    end
                    else
                    begin
                        mem_req.re    = (action == iida_pkg::ACT_GET) && chk_ok;
                        mem_req.raddr = pos_a;
                        state_next    = iida_pkg::ST_RESP;
                    end
                    last_next = mem_req.raddr;
                end
            end
            iida_pkg::ST_SHIFT:
            begin
                mem_req.we    = 1'b1;
                mem_req.wdata = rd_data;
                if (act_reg == iida_pkg::ACT_INSERT)
                begin
                    mem_req.waddr = last_reg + iida_pkg::ADDR_W'(1);
                    mem_req.raddr = last_reg - iida_pkg::ADDR_W'(1);
                end
                else
                begin
                    mem_req.waddr = last_reg - iida_pkg::ADDR_W'(1);
                    mem_req.raddr = last_reg + iida_pkg::ADDR_W'(1);
                end
                if (remain_reg != '0)
                begin
                    mem_req.re  = 1'b1;
                    last_next   = mem_req.raddr;
                    remain_next = remain_reg - iida_pkg::ADDR_W'(1);
                end
                else
                begin
                    state_next = iida_pkg::ST_RESP;
                end
            end
            iida_pkg::ST_RESP:
            begin
                mem_req.we    = (act_reg == iida_pkg::ACT_INSERT)
                                && (stat_reg == iida_pkg::STAT_OK);
                mem_req.waddr = pos_reg;
                mem_req.wdata = val_reg;
                state_next    = iida_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = iida_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= iida_pkg::ST_IDLE;
            count_reg  <= '0;
            act_reg    <= iida_pkg::ACT_GET;
            stat_reg   <= iida_pkg::STAT_OK;
            last_reg   <= '0;
            remain_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            act_reg    <= act_next;
            stat_reg   <= stat_next;
            last_reg   <= last_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        val_reg <= val_next;
    end

    assign busy       = (state_reg != iida_pkg::ST_IDLE);
    assign done       = (state_reg == iida_pkg::ST_RESP);
    assign read_value = (done && (act_reg == iida_pkg::ACT_GET)
                         && (stat_reg == iida_pkg::STAT_OK)) ? rd_data : '0;
    assign length     = iida_pkg::LEN_W'(count_reg);
    assign empty_res  = (count_reg == '0);
    assign status     = stat_reg;

    `ASSERT_NOW(a_no_rw_same_entry, mem_req.we && mem_req.re, mem_req.waddr != mem_req.raddr, "read and write hit the same entry")
    `ASSERT_NOW(a_shift_writes, state_reg == iida_pkg::ST_SHIFT, mem_req.we, "shift cycle without a write")
    `ASSERT_NEXT(a_done_frees, done, !busy, "result not followed by idle")
    `ASSERT_NEXT(a_insert_grows, accept && is_ins && chk_ok, count_reg == $past(count_reg) + iida_pkg::CNT_W'(1), "insert did not grow the count")
    `ASSERT_NOW(a_count_bound, 1'b1, count_reg <= iida_pkg::CNT_W'(iida_pkg::DEPTH), "count above capacity")

endmodule

// File: rtl/indexed_insert_delete_array_top.sv
// Top level: indexed insert/delete list store with fixed capacity.
//
//  channel   handshake          word
//  --------  -----------------  ------------------------------------------
//  command   start && !busy     action, position, value
//  result    done (1 cycle)     read_value, length, empty_res, status
//
//  Get, failed actions, append and delete of the last element go straight
//  from accept to the result state. Insert and delete at other positions
//  first shift the later elements one place through the store, with one
//  store write per shift cycle and a store read in all but the last one.
//  Asynchronous active-low reset empties the list; store contents are not cleared.
//  busy is high from the cycle after accept through the done cycle; results cannot be stalled.
module indexed_insert_delete_array_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [iida_pkg::ACT_W-1:0]  action,
    input  logic [iida_pkg::POS_W-1:0]  position,
    input  logic [iida_pkg::DATA_W-1:0] value,
    output logic                        busy,
    output logic                        done,
    output logic [iida_pkg::DATA_W-1:0] read_value,
    output logic [iida_pkg::LEN_W-1:0]  length,
    output logic                        empty_res,
    output logic [iida_pkg::STAT_W-1:0] status
);

    iida_pkg::mem_req_t          mem_req;
    logic [iida_pkg::DATA_W-1:0] rd_data;

    iida_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .action     (action),
        .position   (position),
        .value      (value),
        .rd_data    (rd_data),
        .mem_req    (mem_req),
        .busy       (busy),
        .done       (done),
        .read_value (read_value),
        .length     (length),
        .empty_res  (empty_res),
        .status     (status)
    );

    iida_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

endmodule

// File: tb/sv/indexed_insert_delete_array_top_test.sv
// Testbench for the indexed insert/delete list store, checked against a built-in list model.
`timescale 1ns / 100ps

module indexed_insert_delete_array_top_test;

    localparam logic [iida_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RUN_WORDS = 450;
    localparam int QUIET_TAIL = 60;

    typedef struct packed {
        logic [iida_pkg::ACT_W-1:0]  op;
        logic [iida_pkg::POS_W-1:0]  pos;
        logic [iida_pkg::DATA_W-1:0] val;
        logic                        drain;
        logic                        quiet;
    } list_cmd_t;

    typedef struct packed {
        logic [iida_pkg::DATA_W-1:0] rd;
        logic [iida_pkg::LEN_W-1:0]  len;
        logic                        empt;
        logic [iida_pkg::STAT_W-1:0] stat;
    } list_reply_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic [iida_pkg::ACT_W-1:0]  action = iida_pkg::ACT_GET;
    logic [iida_pkg::POS_W-1:0]  position = '0;
    logic [iida_pkg::DATA_W-1:0] value = '0;
    logic                        busy;
    logic                        done;
    logic [iida_pkg::DATA_W-1:0] read_value;
    logic [iida_pkg::LEN_W-1:0]  length;
    logic                        empty_res;
    logic [iida_pkg::STAT_W-1:0] status;

    list_cmd_t   cmd_q[$];
    list_reply_t reply_q[$];

    logic [iida_pkg::DATA_W-1:0] list_mem [iida_pkg::DEPTH];
    int list_len = 0;

    int plan_len = 0;
    int plan_words = 0;
    logic plan_quiet = 1'b0;
    logic plan_drain = 1'b0;

    int gap_left = 0;
    int err_cnt = 0;
    int reply_cnt = 0;
    int peak_len = 0;
    int stat_hits [4] = '{0, 0, 0, 0};
    int cycle_cnt = 0;

    indexed_insert_delete_array_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .action     (action),
        .position   (position),
        .value      (value),
        .busy       (busy),
        .done       (done),
        .read_value (read_value),
        .length     (length),
        .empty_res  (empty_res),
        .status     (status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic list_reply_t apply_list_op(logic [iida_pkg::ACT_W-1:0] op,
                                                  logic [iida_pkg::POS_W-1:0] pos,
                                                  logic [iida_pkg::DATA_W-1:0] val);
        list_reply_t r;
        int p;
        r = '0;
        r.stat = iida_pkg::STAT_OK;
        p = pos;
        case (op)
            iida_pkg::ACT_GET:
            begin
                if (list_len == 0)
                    r.stat = iida_pkg::STAT_EMPTY;
                else if (p >= list_len)
                    r.stat = iida_pkg::STAT_RANGE;
                else
                    r.rd = list_mem[p];
            end
            iida_pkg::ACT_INSERT:
            begin
                if (list_len >= iida_pkg::DEPTH)
                    r.stat = iida_pkg::STAT_FULL;
                else if (p > list_len)
                    r.stat = iida_pkg::STAT_RANGE;
                else
                begin
                    for (int k = list_len; k > p; k--)
                        list_mem[k] = list_mem[k - 1];
                    list_mem[p] = val;
                    list_len++;
                end
            end
            iida_pkg::ACT_DELETE:
            begin
                if (list_len == 0)
                    r.stat = iida_pkg::STAT_EMPTY;
                else if (p >= list_len)
                    r.stat = iida_pkg::STAT_RANGE;
                else
                begin
                    for (int k = p; k + 1 < list_len; k++)
                        list_mem[k] = list_mem[k + 1];
                    list_len--;
                end
            end
            default:
            begin
            end
        endcase
        r.len = list_len[iida_pkg::LEN_W-1:0];
        r.empt = (list_len == 0);
        return r;
    endfunction

    task automatic add_cmd(logic [iida_pkg::ACT_W-1:0] op, int pos,
                           logic [iida_pkg::DATA_W-1:0] val);
        list_cmd_t c;
        c.op = op;
        c.pos = pos[iida_pkg::POS_W-1:0];
        c.val = val;
        c.drain = plan_drain;
        c.quiet = plan_quiet || (plan_words >= RUN_WORDS - QUIET_TAIL);
        cmd_q.push_back(c);
        plan_drain = 1'b0;
        plan_words++;
        if (op == iida_pkg::ACT_INSERT && plan_len < iida_pkg::DEPTH && c.pos <= plan_len)
            plan_len++;
        else if (op == iida_pkg::ACT_DELETE && plan_len > 0 && c.pos < plan_len)
            plan_len--;
    endtask

    function automatic int live_pos();
        return (plan_len == 0) ? 0 : $urandom_range(0, plan_len - 1);
    endfunction

    task automatic add_random_cmd();
        logic [iida_pkg::ACT_W-1:0] op;
        int k;
        int pos;
        k = $urandom_range(0, 9);
        if (k < 4)
            op = iida_pkg::ACT_GET;
        else if (k < 7)
            op = iida_pkg::ACT_INSERT;
        else if (k < 9)
            op = iida_pkg::ACT_DELETE;
        else
            op = ACT_UNUSED;
        if ($urandom_range(0, 4) == 0)
            pos = $urandom_range(0, 127);
        else if (op == iida_pkg::ACT_INSERT)
            pos = $urandom_range(0, plan_len);
        else
            pos = live_pos();
        add_cmd(op, pos, $urandom);
    endtask

    // driver
    always @(posedge clk)
    begin
        list_cmd_t nxt;
        logic launch;
        if (rst_n && !(start && busy))
        begin
            launch = 1'b0;
            if (gap_left != 0)
                gap_left <= gap_left - 1;
            else if (cmd_q.size() != 0)
            begin
                nxt = cmd_q[0];
                if (nxt.drain)
                    launch = !start && !busy && (reply_q.size() == 0);
                else if (!nxt.quiet && $urandom_range(0, 4) == 0)
                    gap_left <= $urandom_range(0, 9);
                else
                    launch = 1'b1;
            end
            if (launch)
            begin
                nxt = cmd_q.pop_front();
                action <= nxt.op;
                position <= nxt.pos;
                value <= nxt.val;
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        list_reply_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (reply_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: result with nothing expected (status %0d, length %0d)",
                             $time, status, length);
                end
                else
                begin
                    want = reply_q.pop_front();
                    reply_cnt++;
                    stat_hits[want.stat]++;
                    if (want.len > peak_len)
                        peak_len = want.len;
                    if (read_value !== want.rd)
                    begin
                        err_cnt++;
                        $display("%0t: read_value expected %h got %h",
                                 $time, want.rd, read_value);
                    end
                    if (length !== want.len)
                    begin
                        err_cnt++;
                        $display("%0t: length expected %0d got %0d",
                                 $time, want.len, length);
                    end
                    if (empty_res !== want.empt)
                    begin
                        err_cnt++;
                        $display("%0t: empty_res expected %b got %b",
                                 $time, want.empt, empty_res);
                    end
                    if (status !== want.stat)
                    begin
                        err_cnt++;
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.stat, status);
                    end
                end
            end
            if (start && !busy)
                reply_q.push_back(apply_list_op(action, position, value));
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d words pending, %0d replies due",
                     $time, cmd_q.size(), reply_q.size());
            $display("indexed_insert_delete_array_top_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        int phase_no;
        int sel;
        logic tail_now;
        add_cmd(iida_pkg::ACT_GET, 0, 32'h0);
        add_cmd(iida_pkg::ACT_DELETE, 0, 32'h0);
        add_cmd(ACT_UNUSED, 127, 32'hFFFF_FFFF);
        add_cmd(iida_pkg::ACT_INSERT, 1, 32'h1234_5678);
        add_cmd(iida_pkg::ACT_INSERT, 127, 32'hFFFF_FFFF);
        add_cmd(iida_pkg::ACT_INSERT, 0, 32'h0000_0000);
        add_cmd(iida_pkg::ACT_INSERT, 0, 32'hFFFF_FFFF);
        add_cmd(iida_pkg::ACT_INSERT, 2, 32'hA5A5_A5A5);
        add_cmd(iida_pkg::ACT_INSERT, 1, 32'h5A5A_5A5A);
        add_cmd(iida_pkg::ACT_GET, 0, 32'h0);
        add_cmd(iida_pkg::ACT_GET, 3, 32'h0);
        add_cmd(iida_pkg::ACT_GET, 4, 32'h0);
        add_cmd(iida_pkg::ACT_GET, 127, 32'hFFFF_FFFF);
        add_cmd(iida_pkg::ACT_DELETE, 4, 32'h0);
        add_cmd(iida_pkg::ACT_DELETE, 64, 32'h0);
        plan_drain = 1'b1;
        add_cmd(ACT_UNUSED, 0, 32'h0);
        add_cmd(iida_pkg::ACT_DELETE, 1, 32'h0);
        add_cmd(iida_pkg::ACT_DELETE, 2, 32'h0);
        add_cmd(iida_pkg::ACT_DELETE, 0, 32'h0);
        add_cmd(iida_pkg::ACT_GET, 0, 32'h0);
        add_cmd(iida_pkg::ACT_DELETE, 0, 32'h0);
        add_cmd(iida_pkg::ACT_GET, 0, 32'h0);

        phase_no = 0;
        while (plan_words < RUN_WORDS)
        begin
            tail_now = (plan_words >= RUN_WORDS - QUIET_TAIL);
            plan_quiet = tail_now || ($urandom_range(0, 3) == 0);
            plan_drain = !tail_now && ($urandom_range(0, 2) == 0);
            sel = (phase_no < 2) ? phase_no : $urandom_range(0, 2);
            phase_no++;
            case (sel)
                0:
                begin
                    while (plan_len < iida_pkg::DEPTH)
                    begin
                        if ($urandom_range(0, 4) == 0)
                            add_cmd(iida_pkg::ACT_GET, live_pos(), $urandom);
                        else
                            add_cmd(iida_pkg::ACT_INSERT, $urandom_range(0, plan_len), $urandom);
                    end
                    repeat ($urandom_range(1, 3))
                        add_cmd(iida_pkg::ACT_INSERT, $urandom_range(0, 127), $urandom);
                    add_cmd(iida_pkg::ACT_GET, iida_pkg::DEPTH - 1, $urandom);
                end
                1:
                begin
                    while (plan_len > 0)
                    begin
                        if ($urandom_range(0, 4) == 0)
                            add_cmd(iida_pkg::ACT_GET, live_pos(), $urandom);
                        else
                            add_cmd(iida_pkg::ACT_DELETE, live_pos(), $urandom);
                    end
                    add_cmd(iida_pkg::ACT_GET, $urandom_range(0, 127), $urandom);
                    add_cmd(iida_pkg::ACT_DELETE, $urandom_range(0, 127), $urandom);
                end
                default:
                begin
                    repeat (20)
                        add_random_cmd();
                end
            endcase
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_q.size() != 0 || start)
            @(negedge clk);
        while (reply_q.size() != 0)
            @(negedge clk);
        repeat (iida_pkg::DEPTH + 4) @(negedge clk);

        $display("checked %0d replies: %0d ok, %0d full refusals, %0d out of range, %0d empty",
                 reply_cnt, stat_hits[iida_pkg::STAT_OK], stat_hits[iida_pkg::STAT_FULL],
                 stat_hits[iida_pkg::STAT_RANGE], stat_hits[iida_pkg::STAT_EMPTY]);
        $display("peak list length %0d of %0d, %0d mismatches",
                 peak_len, iida_pkg::DEPTH, err_cnt);
        if (err_cnt == 0)
            $display("indexed_insert_delete_array_top_test: done, clean");
        else
            $display("indexed_insert_delete_array_top_test: done, errors");
        $finish;
    end

endmodule

// File: indexed_insert_delete_array_top.f
+incdir+rtl
rtl/iida_pkg.sv
rtl/iida_mem.sv
rtl/iida_ctrl.sv
rtl/indexed_insert_delete_array_top.sv
tb/sv/indexed_insert_delete_array_top_test.sv
